// ===== rtl/se3x_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// se3x_pkg: shared types and constants of the SE(3) twist exponential core
// Field structs, CORDIC constants and the arctangent table.
// ---------------------------------------------------------------------------
package se3x_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NumCells = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;

  localparam logic signed [33:0] CordicGain = 34'sd652032875;
  localparam logic signed [33:0] HalfPiQ28  = 34'sd421657428;
  localparam logic signed [33:0] PiQ28      = 34'sd843314857;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] lin_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [15:0] trans_x;
    logic signed [15:0] trans_y;
    logic signed [15:0] trans_z;
  } out_item_t;

  // CORDIC datapath word carried from cell to cell.
  typedef struct packed {
    logic               vld;
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    in_item_t           item;
  } cord_t;

  function automatic logic signed [33:0] atan_q28(input int i);
    logic signed [33:0] r;
    begin
      unique case (i)
        0: r = 34'sd210828714;  1: r = 34'sd124459457;
        2: r = 34'sd65760959;   3: r = 34'sd33381290;
        4: r = 34'sd16755422;   5: r = 34'sd8385879;
        6: r = 34'sd4193963;    7: r = 34'sd2097109;
        8: r = 34'sd1048571;    9: r = 34'sd524287;
        10: r = 34'sd262144;    11: r = 34'sd131072;
        12: r = 34'sd65536;     13: r = 34'sd32768;
        14: r = 34'sd16384;     15: r = 34'sd8192;
        16: r = 34'sd4096;      17: r = 34'sd2048;
        18: r = 34'sd1024;      19: r = 34'sd512;
        20: r = 34'sd256;       21: r = 34'sd128;
        22: r = 34'sd64;        default: r = 34'sd32;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    begin
      if (v > 64'sd32767) r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

endpackage

// ===== rtl/se3x_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// se3x_cordic_cell: one CORDIC rotation step
// Turns the vector by atan(2^-STEP) toward the residual angle, registered.
// ---------------------------------------------------------------------------
module se3x_cordic_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [4:0]      step,
  input  wire se3x_pkg::cord_t d_in,
  output se3x_pkg::cord_t      d_out
);

  se3x_pkg::cord_t cell_r, cell_nxt;
  logic signed [33:0] xs, ys;

  always_comb begin
    xs = d_in.x >>> step;
    ys = d_in.y >>> step;
    cell_nxt = d_in;
    if (d_in.z >= 0) begin
      cell_nxt.x = d_in.x - ys;
      cell_nxt.y = d_in.y + xs;
      cell_nxt.z = d_in.z - se3x_pkg::atan_q28(int'(step));
    end else begin
      cell_nxt.x = d_in.x + ys;
      cell_nxt.y = d_in.y - xs;
      cell_nxt.z = d_in.z + se3x_pkg::atan_q28(int'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= d_in.vld;
    end
    cell_r.flip <= cell_nxt.flip;
    cell_r.x    <= cell_nxt.x;
    cell_r.y    <= cell_nxt.y;
    cell_r.z    <= cell_nxt.z;
    cell_r.item <= cell_nxt.item;
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

// ===== rtl/se3x_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// se3x_post: Rodrigues assembly
// Rounds sine and cosine, forms W, W^2 and the rotation and translation.
// ---------------------------------------------------------------------------
module se3x_post (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire se3x_pkg::cord_t    d_in,
  output logic                    out_vld,
  output se3x_pkg::out_item_t     out_item
);

  // Stage 1: sine/cosine and coefficients.
  logic               s1_vld_r;
  logic signed [15:0] s1_s_r, s1_c_r;
  logic signed [15:0] s1_w_r [3];
  logic signed [15:0] s1_v_r [3];
  logic signed [15:0] s1_th_r;

  logic signed [33:0] fx, fy, rx, ry;
  logic signed [15:0] sc, cc;

  always_comb begin
    fx = d_in.flip ? -d_in.x : d_in.x;
    fy = d_in.flip ? -d_in.y : d_in.y;
    rx = (fx + 34'sd32768) >>> 16;
    ry = (fy + 34'sd32768) >>> 16;
    if (rx > 34'sd16384) cc = 16'sd16384;
    else if (rx < -34'sd16384) cc = -16'sd16384;
    else cc = rx[15:0];
    if (ry > 34'sd16384) sc = 16'sd16384;
    else if (ry < -34'sd16384) sc = -16'sd16384;
    else sc = ry[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else s1_vld_r <= d_in.vld;
    s1_s_r  <= sc;
    s1_c_r  <= cc;
    s1_w_r[0] <= d_in.item.axis_x;
    s1_w_r[1] <= d_in.item.axis_y;
    s1_w_r[2] <= d_in.item.axis_z;
    s1_v_r[0] <= d_in.item.lin_x;
    s1_v_r[1] <= d_in.item.lin_y;
    s1_v_r[2] <= d_in.item.lin_z;
    s1_th_r <= d_in.item.angle;
  end

  // Stage 2: skew and squared skew entries (Q.28 products).
  logic               s2_vld_r;
  logic signed [17:0] s2_a_r, s2_b_r;
  logic signed [15:0] s2_s_r, s2_th_r;
  logic signed [16:0] s2_sk_r [3][3];
  logic signed [33:0] s2_sq_r [3][3];
  logic signed [15:0] s2_v_r [3];

  logic signed [16:0] sk_c [3][3];
  logic signed [31:0] pp [3][3];
  logic signed [33:0] sq_c [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        pp[r][k] = s1_w_r[r] * s1_w_r[k];
    sk_c[0][0] = '0;                    sk_c[0][1] = -17'(s1_w_r[2]);
    sk_c[0][2] = 17'(s1_w_r[1]);        sk_c[1][0] = 17'(s1_w_r[2]);
    sk_c[1][1] = '0;                    sk_c[1][2] = -17'(s1_w_r[0]);
    sk_c[2][0] = -17'(s1_w_r[1]);       sk_c[2][1] = 17'(s1_w_r[0]);
    sk_c[2][2] = '0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        sq_c[r][k] = 34'(pp[r][k]);
    sq_c[0][0] = -(34'(pp[1][1]) + 34'(pp[2][2]));
    sq_c[1][1] = -(34'(pp[0][0]) + 34'(pp[2][2]));
    sq_c[2][2] = -(34'(pp[0][0]) + 34'(pp[1][1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else s2_vld_r <= s1_vld_r;
    s2_a_r  <= 18'sd16384 - 18'(s1_c_r);
    s2_b_r  <= 18'(s1_th_r) * 18'sd2 - 18'(s1_s_r);
    s2_s_r  <= s1_s_r;
    s2_th_r <= s1_th_r;
    s2_sk_r <= sk_c;
    s2_sq_r <= sq_c;
    s2_v_r  <= s1_v_r;
  end

  // Stage 3: rotation entries and translation matrix entries.
  // Diagonal translation entries reach beyond 2^33 for large angles.
  logic               s3_vld_r;
  logic signed [15:0] s3_rot_r [3][3];
  logic signed [35:0] s3_tm_r [3][3];
  logic signed [15:0] s3_v_r [3];

  logic signed [63:0] mr, mt;
  logic signed [15:0] rot_c [3][3];
  logic signed [35:0] tm_c [3][3];

  always_comb begin
    mr = '0;
    mt = '0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        mr = 64'(s2_s_r) * 64'(s2_sk_r[r][k]) * 64'sd16384
           + 64'(s2_a_r) * 64'(s2_sq_r[r][k]);
        if (r == k) mr = mr + (64'sd1 <<< 42);
        rot_c[r][k] = se3x_pkg::sat16((mr + (64'sd1 <<< 27)) >>> 28);
        mt = 64'(s2_a_r) * 64'(s2_sk_r[r][k]) * 64'sd16384
           + 64'(s2_b_r) * 64'(s2_sq_r[r][k]);
        if (r == k) mt = mt + ((64'(s2_th_r) * 64'sd2) <<< 28);
        tm_c[r][k] = 36'((mt + 64'sd8192) >>> 14);
      end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else s3_vld_r <= s2_vld_r;
    s3_rot_r <= rot_c;
    s3_tm_r  <= tm_c;
    s3_v_r   <= s2_v_r;
  end

  // Stage 4: translation = matrix times v.
  logic               s4_vld_r;
  se3x_pkg::out_item_t s4_item_r, item_c;
  logic signed [63:0] acc;

  always_comb begin
    item_c = '0;
    item_c.rot_00 = s3_rot_r[0][0]; item_c.rot_01 = s3_rot_r[0][1];
    item_c.rot_02 = s3_rot_r[0][2]; item_c.rot_10 = s3_rot_r[1][0];
    item_c.rot_11 = s3_rot_r[1][1]; item_c.rot_12 = s3_rot_r[1][2];
    item_c.rot_20 = s3_rot_r[2][0]; item_c.rot_21 = s3_rot_r[2][1];
    item_c.rot_22 = s3_rot_r[2][2];
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + 64'(s3_tm_r[0][k]) * 64'(s3_v_r[k]);
    item_c.trans_x = se3x_pkg::sat16((acc + (64'sd1 <<< 27)) >>> 28);
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + 64'(s3_tm_r[1][k]) * 64'(s3_v_r[k]);
    item_c.trans_y = se3x_pkg::sat16((acc + (64'sd1 <<< 27)) >>> 28);
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + 64'(s3_tm_r[2][k]) * 64'(s3_v_r[k]);
    item_c.trans_z = se3x_pkg::sat16((acc + (64'sd1 <<< 27)) >>> 28);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else s4_vld_r <= s3_vld_r;
    s4_item_r <= item_c;
  end

  assign out_vld  = s4_vld_r;
  assign out_item = s4_item_r;

endmodule
`default_nettype wire

// ===== rtl/se3_twist_exponential_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// se3_twist_exponential_core: SE(3) exponential map of a screw axis
// CORDIC cell chain for sine/cosine followed by Rodrigues assembly.
// ---------------------------------------------------------------------------
// Channel   Ports                    Transfer
// input     start, busy, in_item     start high while busy low
// result    out_valid, out_item      one-cycle strobe, no backpressure
//
// One transaction is taken every cycle; busy is held low.
// Between input and result lie one input register, one register per CORDIC
// cell and four assembly stages. Reset clears only the valid bits.
// ---------------------------------------------------------------------------
module se3_twist_exponential_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire se3x_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output se3x_pkg::out_item_t       out_item
);

  se3x_pkg::cord_t chain [se3x_pkg::NumCells + 1];
  se3x_pkg::cord_t head_r, head_nxt;
  logic signed [33:0] z0;

  assign busy = 1'b0;

  // Fold the angle into the CORDIC range by a half turn.
  always_comb begin
    z0 = 34'(in_item.angle) <<< 15;
    head_nxt.vld  = start;
    head_nxt.item = in_item;
    head_nxt.x    = se3x_pkg::CordicGain;
    head_nxt.y    = '0;
    head_nxt.flip = 1'b0;
    head_nxt.z    = z0;
    if (z0 > se3x_pkg::HalfPiQ28) begin
      head_nxt.z = z0 - se3x_pkg::PiQ28;
      head_nxt.flip = 1'b1;
    end else if (z0 < -se3x_pkg::HalfPiQ28) begin
      head_nxt.z = z0 + se3x_pkg::PiQ28;
      head_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) head_r.vld <= 1'b0;
    else head_r.vld <= head_nxt.vld;
    head_r.flip <= head_nxt.flip;
    head_r.x    <= head_nxt.x;
    head_r.y    <= head_nxt.y;
    head_r.z    <= head_nxt.z;
    head_r.item <= head_nxt.item;
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < se3x_pkg::NumCells; g++) begin : g_cell
    se3x_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (5'(g)),
      .d_in  (chain[g]),
      .d_out (chain[g + 1])
    );
  end

  se3x_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_in     (chain[se3x_pkg::NumCells]),
    .out_vld  (out_valid),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(se3x_pkg::NumCells + 5) out_valid)
    else $error("result missing after fixed latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, se3x_pkg::NumCells + 5))
    else $error("result without a transaction");
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r.vld && head_r.z == 34'sd0) |-> !head_r.flip)
    else $error("zero angle folded");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_se3_twist_exponential_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_se3_twist_exponential_core: self-checking bench of the twist exponential
// Drives screw axes and angles in random bursts, predicts the rigid transform
// with its own CORDIC and Rodrigues model, and checks every output transaction.
// ---------------------------------------------------------------------------
module tb_se3_twist_exponential_core;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles = se3x_pkg::NumCells + 10;

  localparam longint ArcTan [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32};

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  se3x_pkg::in_item_t  in_item;
  logic                out_valid;
  se3x_pkg::out_item_t out_item;

  se3x_pkg::in_item_t  twist_q[$];
  bit                  drain_q[$];
  se3x_pkg::out_item_t transform_q[$];
  bit        taken;
  int        errors;
  int        idle_cycles;
  int        burst_left;
  int        gap_left;
  bit        stim_done;

  se3_twist_exponential_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic se3x_pkg::out_item_t twist_exp(input se3x_pkg::in_item_t t);
    longint w [3];
    longint lv [3];
    longint skew [3][3];
    longint sq [3][3];
    longint th, z, x, y, nx, sn, cs, a, b, m, acc;
    bit flip;
    logic [15:0] res [12];
    se3x_pkg::out_item_t o;
    w[0] = t.axis_x; w[1] = t.axis_y; w[2] = t.axis_z;
    lv[0] = t.lin_x; lv[1] = t.lin_y; lv[2] = t.lin_z;
    th = t.angle;
    // Fold the angle into the CORDIC range by a half turn, then negate.
    z = th * 32768;
    x = 652032875;
    y = 0;
    flip = 0;
    if (z > 421657428) begin
      z -= 843314857; flip = 1;
    end else if (z < -421657428) begin
      z += 843314857; flip = 1;
    end
    for (int i = 0; i < se3x_pkg::NumCells; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ArcTan[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ArcTan[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = round_q(x, 16);
    sn = round_q(y, 16);
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    if (sn > 16384) sn = 16384;
    if (sn < -16384) sn = -16384;
    a = 16384 - cs;
    b = 2 * th - sn;
    skew[0][0] = 0;     skew[0][1] = -w[2]; skew[0][2] = w[1];
    skew[1][0] = w[2];  skew[1][1] = 0;     skew[1][2] = -w[0];
    skew[2][0] = -w[1]; skew[2][1] = w[0];  skew[2][2] = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        sq[r][k] = (r == k) ? 0 : w[r] * w[k];
    sq[0][0] = -(w[1] * w[1] + w[2] * w[2]);
    sq[1][1] = -(w[0] * w[0] + w[2] * w[2]);
    sq[2][2] = -(w[0] * w[0] + w[1] * w[1]);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        m = sn * skew[r][k] * 16384 + a * sq[r][k];
        if (r == k) m += longint'(1) <<< 42;
        res[r * 3 + k] = clamp16(round_q(m, 28));
        m = a * skew[r][k] * 16384 + b * sq[r][k];
        if (r == k) m += 2 * th * (longint'(1) <<< 28);
        acc += round_q(m, 14) * lv[k];
      end
      res[9 + r] = clamp16(round_q(acc, 28));
    end
    for (int k = 0; k < 12; k++) o[191 - 16 * k -: 16] = res[k];
    return o;
  endfunction

  function automatic se3x_pkg::in_item_t random_twist();
    se3x_pkg::in_item_t t;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // Near-unit axes keep the transform inside range most of the time.
      t.axis_x = 16'($urandom_range(0, 32768) - 16384);
      t.axis_y = 16'($urandom_range(0, 32768) - 16384);
      t.axis_z = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      t.axis_x = 16'($urandom); t.axis_y = 16'($urandom); t.axis_z = 16'($urandom);
    end
    t.lin_x = 16'($urandom); t.lin_y = 16'($urandom); t.lin_z = 16'($urandom);
    if (sel < 8) begin
      t.lin_x = $signed(t.lin_x) >>> $urandom_range(0, 8);
      t.lin_y = $signed(t.lin_y) >>> $urandom_range(0, 8);
      t.lin_z = $signed(t.lin_z) >>> $urandom_range(0, 8);
    end
    // Now and then the angle covers the whole field, beyond plus or minus pi.
    if (sel == 9) t.angle = 16'($urandom);
    else t.angle = 16'($urandom_range(0, 51472) - 25736);
    return t;
  endfunction

  task automatic add_twist(input int ax, input int ay, input int az,
                           input int lx, input int ly, input int lz,
                           input int ang);
    twist_q.push_back('{16'(ax), 16'(ay), 16'(az), 16'(lx), 16'(ly), 16'(lz),
                        16'(ang)});
    drain_q.push_back(0);
  endtask

  function automatic string field_name(input int k);
    string names [12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                          "rot_20", "rot_21", "rot_22", "trans_x", "trans_y", "trans_z"};
    return names[k];
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
  end

  initial begin
    add_twist(0, 0, 16384, 256, 0, 0, 0);
    add_twist(0, 0, 16384, 256, 256, 256, 12868);
    add_twist(16384, 0, 0, 256, -256, 512, 12869);
    add_twist(0, 16384, 0, 256, 256, -256, -12868);
    add_twist(0, 16384, 0, 256, 256, -256, -12869);
    add_twist(0, 0, 16384, 1000, 2000, -3000, 25736);
    add_twist(16384, 0, 0, -1000, 2000, 3000, -25736);
    add_twist(9459, 9459, 9459, 256, 256, 256, 8579);
    add_twist(0, 0, 0, 32767, -32768, 1, 20000);
    add_twist(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 25736);
    add_twist(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, -25736);
    add_twist(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 12868);
    add_twist(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, -1);
    add_twist(-16384, 0, 0, -32768, 32767, 0, 1);
    add_twist(16384, 16384, 16384, 4096, 4096, 4096, 25000);
    add_twist(0, -16384, 0, 0, 0, 32767, -20000);
    add_twist(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    add_twist(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    add_twist(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_twist(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    drain_q[$] = 1;
    for (int n = 0; n < 1050; n++) begin
      twist_q.push_back(random_twist());
      drain_q.push_back((n % 350) == 349);
    end
    stim_done = 1;
  end

  // Driver: bursts of back-to-back transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_item <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      // The accepted transaction leaves the queue, so the next one is at the front.
      if (taken) begin
        void'(twist_q.pop_front());
        void'(drain_q.pop_front());
      end
      if (gap_left > 0) begin
        start <= 0;
        gap_left <= gap_left - 1;
      end else if (twist_q.size() > 0) begin
        if (drain_q[0] && transform_q.size() != 0) begin
          start <= 0;
        end else begin
          start <= 1;
          in_item <= twist_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        start <= 0;
      end
    end
  end

  // Monitor: record accepted twists and check each output transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      taken <= 0;
      idle_cycles <= 0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) transform_q.push_back(twist_exp(in_item));
      if (out_valid) begin
        if (transform_q.size() == 0) begin
          $error("unexpected output transaction");
          errors++;
        end else begin
          se3x_pkg::out_item_t want;
          want = transform_q.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (want[191 - 16 * k -: 16] !== out_item[191 - 16 * k -: 16]) begin
              $error("%s: expected %0d, got %0d", field_name(k),
                     $signed(want[191 - 16 * k -: 16]),
                     $signed(out_item[191 - 16 * k -: 16]));
              errors++;
            end
          end
        end
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (stim_done && twist_q.size() == 0 && transform_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && transform_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
